// ===== design/rti_pkg.sv =====
// Shared types and constants for the ray/triangle intersection pipeline.
// No dependencies; every design file imports this package.
package rti_pkg;

  // Coordinate width and the exact widths of the intermediate terms
  localparam int CW    = 32;
  localparam int EW    = CW + 1;
  localparam int XW    = 2 * EW + 1;
  localparam int DOTW  = 3 * EW + 3;
  localparam int NUMW  = EW + DOTW;
  localparam int QW    = EW;
  localparam int MULCW = 32;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;

  typedef struct packed {
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
    logic signed [CW-1:0] c_x;
    logic signed [CW-1:0] c_y;
    logic signed [CW-1:0] c_z;
  } rti_in_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
  } rti_out_t;

  // Side flags that ride along the divider stages
  typedef struct packed {
    logic       hit;
    logic [2:0] neg;
  } rti_tag_t;

endpackage

// ===== design/rti_mul.sv =====
// Two-stage signed multiplier: partial products of a by chunks of b of at most 34 bits, then a sum.
// Depends on rti_pkg for the partial product chunk width.
module rti_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                 clk,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);
  import rti_pkg::*;

  localparam int NC  = (BW - 3) / MULCW + 1;
  localparam int TW  = BW - MULCW * (NC - 1);
  localparam int PPW = AW + ((TW > MULCW + 1) ? TW : MULCW + 1);

  logic signed [PPW-1:0]    pp_r [NC];
  logic signed [AW+BW-1:0]  acc;

  // Stage one: one partial product per chunk of b, low chunks unsigned
  for (genvar g = 0; g < NC; g++) begin : g_pp
    if (g < NC - 1) begin : g_lo
      always_ff @(posedge clk) begin
        pp_r[g] <= PPW'(a) * PPW'($signed({1'b0, b[g*MULCW +: MULCW]}));
      end
    end else begin : g_top
      always_ff @(posedge clk) begin
        pp_r[g] <= PPW'(a) * PPW'($signed(b[BW-1:g*MULCW]));
      end
    end
  end

  // Stage two: align and add the partial products
  always_comb begin
    acc = '0;
    for (int i = 0; i < NC; i++) begin
      acc = acc + ((AW+BW)'(pp_r[i]) <<< (i * MULCW));
    end
  end

  always_ff @(posedge clk) begin
    p <= acc;
  end

endmodule

// ===== design/rti_div.sv =====
// Pipelined restoring divider for three lanes sharing one divisor, one bit per stage.
// Depends on rti_pkg for widths and the side flag struct.
module rti_div (
  input  logic                        clk,
  input  logic [2:0][rti_pkg::NUMW-1:0] num,
  input  logic [rti_pkg::DOTW-1:0]    den,
  input  rti_pkg::rti_tag_t           tag_i,
  output logic [2:0][rti_pkg::QW-1:0] quo,
  output rti_pkg::rti_tag_t           tag_o
);
  import rti_pkg::*;

  logic [DOTW-1:0]        den_r [QW+1];
  rti_tag_t               tag_r [QW+1];
  logic [2:0][DOTW-1:0]   rem_r [QW+1];
  logic [2:0][QW-1:0]     lo_r  [QW];
  logic [2:0][QW-1:0]     q_r   [QW+1];
  logic [2:0]             ovf_r [QW+1];

  // Entry stage: split the dividend, flag quotients that cannot fit
  always_ff @(posedge clk) begin
    den_r[0] <= den;
    tag_r[0] <= tag_i;
    for (int l = 0; l < 3; l++) begin
      rem_r[0][l] <= num[l][NUMW-1:QW];
      lo_r[0][l]  <= num[l][QW-1:0];
      q_r[0][l]   <= '0;
      ovf_r[0][l] <= (num[l][NUMW-1:QW] >= den);
    end
  end

  // One quotient bit per stage
  for (genvar g = 1; g <= QW; g++) begin : g_stage
    logic [2:0][DOTW-1:0] trial;
    logic [2:0]           take;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        trial[l] = {rem_r[g-1][l][DOTW-2:0], lo_r[g-1][l][QW-1]};
        take[l]  = (trial[l] >= den_r[g-1]);
      end
    end

    always_ff @(posedge clk) begin
      den_r[g] <= den_r[g-1];
      tag_r[g] <= tag_r[g-1];
      ovf_r[g] <= ovf_r[g-1];
      for (int l = 0; l < 3; l++) begin
        rem_r[g][l] <= take[l] ? (trial[l] - den_r[g-1]) : trial[l];
        q_r[g][l]   <= {q_r[g-1][l][QW-2:0], take[l]};
      end
    end

    if (g < QW) begin : g_lo
      always_ff @(posedge clk) begin
        for (int l = 0; l < 3; l++) begin
          lo_r[g][l] <= {lo_r[g-1][l][QW-2:0], 1'b0};
        end
      end
    end
  end

  // Clamp overflowed quotients to full scale
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      quo[l] = ovf_r[QW][l] ? {QW{1'b1}} : q_r[QW][l];
    end
  end

  assign tag_o = tag_r[QW];

endmodule

// ===== design/ray_triangle_intersect.sv =====
// Ray/triangle intersection top level; uses rti_pkg, rti_mul and rti_div.
// Throughput: one triangle word per cycle; busy is low whenever rst_n is high.
// Depth is set by the 34-stage divider for the hit point.
// Reset (synchronous, active low) empties the pipeline and restores the ray.
// The receiver cannot stall: every result is shown for exactly one cycle.
module ray_triangle_intersect #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  rti_pkg::rti_in_t                  in_word,
  output logic                              out_valid,
  output rti_pkg::rti_out_t                 out_word,
  input  logic                              cfg_we,
  input  logic [rti_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [rti_pkg::CW-1:0]            cfg_data
);
  import rti_pkg::*;

  localparam int LAT = 15 + QW;
  localparam logic [CW-1:0] DIR_Z_RST = -(CW'(1) << FRAC_BITS);

  // Ray registers
  logic signed [CW-1:0] org_x_r, org_y_r, org_z_r;
  logic signed [CW-1:0] dir_x_r, dir_y_r, dir_z_r;
  logic signed [EW-1:0] ov [3];
  logic signed [EW-1:0] dv [3];

  logic [LAT-1:0] vld_r;

  logic signed [EW-1:0] e1_p [4][3];
  logic signed [EW-1:0] e2_p [4][3];
  logic signed [EW-1:0] s_p  [4][3];

  logic signed [2*EW-1:0] qa_p [3];
  logic signed [2*EW-1:0] qb_p [3];
  logic signed [2*EW-1:0] ra_p [3];
  logic signed [2*EW-1:0] rb_p [3];
  logic signed [XW-1:0]   q_r  [3];
  logic signed [XW-1:0]   r_r  [3];

  logic signed [EW+XW-1:0] pden [3];
  logic signed [EW+XW-1:0] pun  [3];
  logic signed [EW+XW-1:0] pvn  [3];
  logic signed [EW+XW-1:0] ptn  [3];

  logic signed [DOTW-1:0] den_r, un_r, vn_r, tn_r;
  logic signed [DOTW-1:0] denn_r, unn_r, vnn_r, tnn_r;
  logic signed [DOTW-1:0] slack;
  logic signed [DOTW-1:0] den_h_r, tn_h_r;
  logic                   hit_h_r;
  logic [DOTW-1:0]        den_d_r [2];
  logic                   hit_d_r [2];

  logic signed [NUMW-1:0]   num_p [3];
  logic [2:0][NUMW-1:0]     nabs_r;
  logic [DOTW-1:0]          den_a_r;
  rti_tag_t                 tag_a_r;

  logic [2:0][QW-1:0]       quo;
  rti_tag_t                 tag_q;
  logic signed [QW:0]       qs_r [3];
  logic                     hit_f_r;

  logic signed [CW+2:0]     psum [3];
  logic signed [CW-1:0]     psat [3];
  rti_out_t                 out_r;

  assign busy = ~rst_n;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0;
      org_y_r <= '0;
      org_z_r <= '0;
      dir_x_r <= '0;
      dir_y_r <= '0;
      dir_z_r <= DIR_Z_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ORIGIN_X: org_x_r <= cfg_data;
        REG_ORIGIN_Y: org_y_r <= cfg_data;
        REG_ORIGIN_Z: org_z_r <= cfg_data;
        REG_DIR_X:    dir_x_r <= cfg_data;
        REG_DIR_Y:    dir_y_r <= cfg_data;
        REG_DIR_Z:    dir_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ov[0] = EW'(org_x_r);
  assign ov[1] = EW'(org_y_r);
  assign ov[2] = EW'(org_z_r);
  assign dv[0] = EW'(dir_x_r);
  assign dv[1] = EW'(dir_y_r);
  assign dv[2] = EW'(dir_z_r);

  // Valid bits travel with the words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start & ~busy};
    end
  end

  // Stage 1: edges and origin offset
  always_ff @(posedge clk) begin
    e1_p[0][0] <= EW'(in_word.b_x) - EW'(in_word.a_x);
    e1_p[0][1] <= EW'(in_word.b_y) - EW'(in_word.a_y);
    e1_p[0][2] <= EW'(in_word.b_z) - EW'(in_word.a_z);
    e2_p[0][0] <= EW'(in_word.c_x) - EW'(in_word.a_x);
    e2_p[0][1] <= EW'(in_word.c_y) - EW'(in_word.a_y);
    e2_p[0][2] <= EW'(in_word.c_z) - EW'(in_word.a_z);
    s_p[0][0]  <= EW'(org_x_r) - EW'(in_word.a_x);
    s_p[0][1]  <= EW'(org_y_r) - EW'(in_word.a_y);
    s_p[0][2]  <= EW'(org_z_r) - EW'(in_word.a_z);
  end

  // Hold the edge vectors and origin offset until the dot products need them
  always_ff @(posedge clk) begin
    for (int k = 1; k < 4; k++) begin
      e1_p[k] <= e1_p[k-1];
      e2_p[k] <= e2_p[k-1];
      s_p[k]  <= s_p[k-1];
    end
  end

  // Stages 2-4: cross products q = D x e2 and r = s x e1
  for (genvar i = 0; i < 3; i++) begin : g_cross
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    rti_mul #(.AW(EW), .BW(EW)) u_qa (.clk(clk), .a(dv[J]), .b(e2_p[0][K]), .p(qa_p[i]));
    rti_mul #(.AW(EW), .BW(EW)) u_qb (.clk(clk), .a(dv[K]), .b(e2_p[0][J]), .p(qb_p[i]));
    rti_mul #(.AW(EW), .BW(EW)) u_ra (.clk(clk), .a(s_p[0][J]), .b(e1_p[0][K]), .p(ra_p[i]));
    rti_mul #(.AW(EW), .BW(EW)) u_rb (.clk(clk), .a(s_p[0][K]), .b(e1_p[0][J]), .p(rb_p[i]));

    always_ff @(posedge clk) begin
      q_r[i] <= XW'(qa_p[i]) - XW'(qb_p[i]);
      r_r[i] <= XW'(ra_p[i]) - XW'(rb_p[i]);
    end

    // Stages 5-6: products for the four dot products
    rti_mul #(.AW(EW), .BW(XW)) u_den (.clk(clk), .a(e1_p[3][i]), .b(q_r[i]), .p(pden[i]));
    rti_mul #(.AW(EW), .BW(XW)) u_un  (.clk(clk), .a(s_p[3][i]),  .b(q_r[i]), .p(pun[i]));
    rti_mul #(.AW(EW), .BW(XW)) u_vn  (.clk(clk), .a(dv[i]),      .b(r_r[i]), .p(pvn[i]));
    rti_mul #(.AW(EW), .BW(XW)) u_tn  (.clk(clk), .a(e2_p[3][i]), .b(r_r[i]), .p(ptn[i]));
  end

  // Stage 7: sum the dot products
  always_ff @(posedge clk) begin
    den_r <= DOTW'(pden[0]) + DOTW'(pden[1]) + DOTW'(pden[2]);
    un_r  <= DOTW'(pun[0])  + DOTW'(pun[1])  + DOTW'(pun[2]);
    vn_r  <= DOTW'(pvn[0])  + DOTW'(pvn[1])  + DOTW'(pvn[2]);
    tn_r  <= DOTW'(ptn[0])  + DOTW'(ptn[1])  + DOTW'(ptn[2]);
  end

  // Stage 8: flip all terms so the denominator is non-negative
  always_ff @(posedge clk) begin
    denn_r <= den_r[DOTW-1] ? -den_r : den_r;
    unn_r  <= den_r[DOTW-1] ? -un_r  : un_r;
    vnn_r  <= den_r[DOTW-1] ? -vn_r  : vn_r;
    tnn_r  <= den_r[DOTW-1] ? -tn_r  : tn_r;
  end

  // Stage 9: hit test on the barycentric numerators and t
  assign slack = denn_r - unn_r - vnn_r;

  always_ff @(posedge clk) begin
    hit_h_r <= (denn_r != '0) && !unn_r[DOTW-1] && !vnn_r[DOTW-1] && !slack[DOTW-1]
               && !tnn_r[DOTW-1] && (tnn_r != '0);
    den_h_r <= denn_r;
    tn_h_r  <= tnn_r;
  end

  // Stages 10-11: D * t numerators, with divisor and hit held alongside
  for (genvar i = 0; i < 3; i++) begin : g_num
    rti_mul #(.AW(EW), .BW(DOTW)) u_num (.clk(clk), .a(dv[i]), .b(tn_h_r), .p(num_p[i]));
  end

  always_ff @(posedge clk) begin
    den_d_r[0] <= den_h_r;
    hit_d_r[0] <= hit_h_r;
    den_d_r[1] <= den_d_r[0];
    hit_d_r[1] <= hit_d_r[0];
  end

  // Stage 12: magnitudes and signs for the divider
  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      nabs_r[l]      <= num_p[l][NUMW-1] ? NUMW'(-num_p[l]) : NUMW'(num_p[l]);
      tag_a_r.neg[l] <= num_p[l][NUMW-1];
    end
    tag_a_r.hit <= hit_d_r[1];
    den_a_r     <= den_d_r[1];
  end

  // Truncating division of the point offsets
  rti_div u_div (
    .clk  (clk),
    .num  (nabs_r),
    .den  (den_a_r),
    .tag_i(tag_a_r),
    .quo  (quo),
    .tag_o(tag_q)
  );

  // Restore the sign of each offset
  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      qs_r[l] <= tag_q.neg[l] ? -$signed({1'b0, quo[l]}) : $signed({1'b0, quo[l]});
    end
    hit_f_r <= tag_q.hit;
  end

  // Add to the origin and saturate
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      psum[l] = (CW+3)'(ov[l]) + (CW+3)'(qs_r[l]);
      if (psum[l] > $signed((CW+3)'({1'b0, {(CW-1){1'b1}}}))) begin
        psat[l] = {1'b0, {(CW-1){1'b1}}};
      end else if (psum[l] < -$signed((CW+3)'({1'b1, {(CW-1){1'b0}}}))) begin
        psat[l] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        psat[l] = psum[l][CW-1:0];
      end
    end
  end

  // Output register; points read zero on a miss
  always_ff @(posedge clk) begin
    out_r.hit     <= hit_f_r;
    out_r.point_x <= hit_f_r ? psat[0] : '0;
    out_r.point_y <= hit_f_r ? psat[1] : '0;
    out_r.point_z <= hit_f_r ? psat[2] : '0;
  end

  assign out_word  = out_r;
  assign out_valid = vld_r[LAT-1];

  // Every accepted word produces its strobe after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result strobe missing after fixed latency");

  // A miss reports a zero point
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.hit) |->
      (out_word.point_x == '0 && out_word.point_y == '0 && out_word.point_z == '0))
    else $error("miss with nonzero point");

  // Reset flushes the pipeline
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("strobe right after reset");

  // A zero denominator never survives the hit test
  a_den_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (denn_r == '0) |=> !hit_h_r)
    else $error("hit with zero denominator");

endmodule
